// ===== hw/rtl/iida_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and codes for the indexed insert / delete array.
// ----------------------------------------------------------------------------
package iida_pkg;

    localparam int ElemW   = 32;
    localparam int ModeW   = 3;
    localparam int PosW    = 6;
    localparam int CountW  = 7;
    localparam int StatusW = 2;

    typedef logic signed [ElemW-1:0] elem_t;

    typedef enum logic [ModeW-1:0] {
        MODE_APPEND      = 3'd0,
        MODE_INSERT      = 3'd1,
        MODE_POP         = 3'd2,
        MODE_REMOVE_LAST = 3'd3,
        MODE_REMOVE_AT   = 3'd4
    } mode_t;

    typedef enum logic [StatusW-1:0] {
        ST_DONE     = 2'd0,
        ST_POSITION = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // shift_deep: move items away from cell 0, shift_near: move towards it
    typedef struct packed {
        logic shift_deep;
        logic shift_near;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/iida_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iida_cell
// One storage cell of the chain; holds one element and takes data from
// either neighbour or the incoming value, as the broadcast control says.
// ----------------------------------------------------------------------------
module iida_cell #(
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  wire                      aclk,
    input  wire iida_pkg::cell_ctl_t ctl,
    input  wire [CW-1:0]             thr,
    input  wire iida_pkg::elem_t     value_in,
    input  wire iida_pkg::elem_t     prev_data,
    input  wire iida_pkg::elem_t     next_data,
    output iida_pkg::elem_t          data_out
);
    import iida_pkg::*;

    localparam logic [CW-1:0] MyIndex = CW'(INDEX);

    elem_t data_reg;
    elem_t data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift_deep) begin
            if (MyIndex == thr) begin
                data_next = value_in;
            end else if (MyIndex > thr) begin
                data_next = prev_data;
            end
        end else if (ctl.shift_near) begin
            if (MyIndex >= thr) begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_insert_delete_array_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top
// Ordered array of signed 32-bit elements with append, insert, pop and
// remove operations, kept in a chain of cells.
//
// The slave channel takes one operation per item: the mode in s_tuser, the
// value and position in s_tdata. The master channel returns one result per
// item: popped value, element count after the operation and status.
// Elements are stored newest-last-first: cell 0 always holds the last
// element, so append and pop are shifts of the whole chain and insert or
// remove at a position shift the cells on one side of a broadcast threshold.
// Every operation updates the chain in the cycle it is accepted; the result
// sits in the output register from the next cycle. One item per cycle is
// sustained while the receiver takes results; the output register lets the
// next item in during the cycle a result is taken.
// When the receiver stalls, the result holds and s_tready drops until it is
// taken. Reset empties the array (count to zero) and drops m_tvalid; the
// cell contents are not cleared and are never read unwritten.
// Refused operations (full, empty, bad position) leave the array unchanged.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top #(
    parameter int CAPACITY = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // value[31:0], position[37:32], zero pad
    input  wire  [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // popped_value[31:0], element_count[38:32],
                                   // status[40:39], zero pad
);
    import iida_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > PosW) ? CW : PosW;
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    logic              s_acc;
    elem_t             in_value;
    logic [PosW-1:0]   in_pos;
    logic [CMPW-1:0]   pos_w;
    logic [CMPW-1:0]   cnt_w;
    logic              is_full;
    logic              is_empty;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    cell_ctl_t         op_ctl;
    cell_ctl_t         cell_ctl;
    logic [CW-1:0]     thr;
    status_t           op_status;
    elem_t             op_popped;

    logic              out_valid_reg;
    elem_t             out_popped_reg;
    logic [CountW-1:0] out_count_reg;
    status_t           out_status_reg;

    elem_t             cell_data [CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign in_value = elem_t'(s_tdata[31:0]);
    assign in_pos   = s_tdata[37:32];
    assign pos_w    = CMPW'(in_pos);
    assign cnt_w    = CMPW'(count_reg);
    assign is_full  = (count_reg == CapCount);
    assign is_empty = (count_reg == '0);

    always_comb begin
        op_ctl     = '0;
        thr        = '0;
        op_status  = ST_DONE;
        count_next = count_reg;
        op_popped  = '0;
        unique case (s_tuser)
            MODE_APPEND: begin
                if (is_full) begin
                    op_status = ST_FULL;
                end else begin
                    op_ctl.shift_deep = 1'b1;
                    count_next        = count_reg + 1'b1;
                end
            end
            MODE_INSERT: begin
                if (pos_w >= cnt_w) begin
                    op_status = ST_POSITION;
                end else if (is_full) begin
                    op_status = ST_FULL;
                end else begin
                    op_ctl.shift_deep = 1'b1;
                    thr               = CW'(cnt_w - pos_w);
                    count_next        = count_reg + 1'b1;
                end
            end
            MODE_POP: begin
                if (is_empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    op_ctl.shift_near = 1'b1;
                    count_next        = count_reg - 1'b1;
                    op_popped         = cell_data[0];
                end
            end
            MODE_REMOVE_LAST: begin
                if (is_empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    op_ctl.shift_near = 1'b1;
                    count_next        = count_reg - 1'b1;
                end
            end
            MODE_REMOVE_AT: begin
                if (is_empty) begin
                    op_status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    op_status = ST_POSITION;
                end else begin
                    op_ctl.shift_near = 1'b1;
                    thr               = CW'(cnt_w - pos_w - 1'b1);
                    count_next        = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign cell_ctl = s_acc ? op_ctl : '0;

    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        elem_t prev_d;
        elem_t next_d;
        if (j == 0) begin : g_first
            assign prev_d = in_value;
        end else begin : g_prev
            assign prev_d = cell_data[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_next
            assign next_d = cell_data[j+1];
        end
        iida_cell #(
            .CW    (CW),
            .INDEX (j)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl),
            .thr       (thr),
            .value_in  (in_value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data_out  (cell_data[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_popped_reg <= op_popped;
            out_count_reg  <= CountW'(count_next);
            out_status_reg <= op_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_count_reg, out_popped_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CapCount)
        else $error("count above capacity");

    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && op_status != ST_DONE) |=> (count_reg == $past(count_reg)))
        else $error("refused operation changed count");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == MODE_POP && !is_empty)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not drop one element");

    a_count_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[38:32] == CountW'(count_reg)))
        else $error("reported count differs from stored count");

endmodule
`default_nettype wire
